@@ sv/m2e_pkg.sv @@
// Shared types, constants and helper function of the memory map to E820 converter.
// No dependencies; every other file of the block imports this package.
package m2e_pkg;

  localparam int MAX_ENTRIES       = 32;
  localparam int SHIM_REGION_BYTES = 65536;
  localparam int QDEPTH            = 4;
  localparam int QPTR_W            = $clog2(QDEPTH);
  localparam int QCNT_W            = $clog2(QDEPTH + 1);
  localparam int SLOTS             = 3;

  localparam int BASE_W  = 52;
  localparam int LEN_W   = 53;
  localparam int PAGE_W  = 40;
  localparam int TYPE_W  = 32;
  localparam int TOTAL_W = 6;

  localparam logic [LEN_W-1:0] ONE_MEG = 53'h10_0000;

  localparam int REG_ADDR_W = 4;
  localparam logic [1:0] REG_LOW_TOP    = 2'd0;
  localparam logic [1:0] REG_DISK_BASE  = 2'd1;
  localparam logic [1:0] REG_DISK_SIZE  = 2'd2;
  localparam logic [1:0] REG_GUARD_BASE = 2'd3;

  localparam logic [20:0] LOW_TOP_RESET = 21'h0A_0000;
  localparam logic [20:0] SHIM_BYTES    = 21'(SHIM_REGION_BYTES);

  localparam logic [TYPE_W-1:0] FW_LOADER_CODE  = 32'd1;
  localparam logic [TYPE_W-1:0] FW_LOADER_DATA  = 32'd2;
  localparam logic [TYPE_W-1:0] FW_BS_CODE      = 32'd3;
  localparam logic [TYPE_W-1:0] FW_BS_DATA      = 32'd4;
  localparam logic [TYPE_W-1:0] FW_CONVENTIONAL = 32'd7;
  localparam logic [TYPE_W-1:0] FW_ACPI_RECLAIM = 32'd9;
  localparam logic [TYPE_W-1:0] FW_ACPI_NVS     = 32'd10;

  localparam logic [TOTAL_W-1:0] FIXED_ENTRIES = 6'd2;

  typedef enum logic [2:0] {
    KIND_USABLE       = 3'd1,
    KIND_RESERVED     = 3'd2,
    KIND_ACPI_RECLAIM = 3'd3,
    KIND_ACPI_NVS     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [20:0] low_top;
    logic [31:0] disk_base;
    logic [32:0] disk_end;
    logic [19:0] guard_base;
    logic [20:0] guard_end;
  } cfg_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [LEN_W-1:0]   length;
    kind_t              kind;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } result_t;

  typedef struct packed {
    result_t [SLOTS-1:0] res;
    logic [1:0]          cnt;
  } bundle_t;

  typedef struct packed {
    logic [BASE_W-1:0] s;
    logic [LEN_W-1:0]  e;
    logic [LEN_W-1:0]  len;
    kind_t             t;
    logic              hit;
    logic              eom;
  } desc_t;

  function automatic kind_t kind_of(input logic [TYPE_W-1:0] fw_type);
    kind_t k;
    case (fw_type) inside
      FW_LOADER_CODE, FW_LOADER_DATA, FW_BS_CODE, FW_BS_DATA, FW_CONVENTIONAL:
        k = KIND_USABLE;
      FW_ACPI_RECLAIM: k = KIND_ACPI_RECLAIM;
      FW_ACPI_NVS:     k = KIND_ACPI_NVS;
      default:         k = KIND_RESERVED;
    endcase
    return k;
  endfunction

endpackage

@@ sv/memory_map_to_e820_converter_core.sv @@
// Top level of the firmware memory map to E820 table converter.
// Depends on m2e_pkg, m2e_regs, m2e_front, m2e_queue and m2e_back.
//
// Descriptors enter on the in_ channel, one request per descriptor, with the
// final descriptor of a map flagged by in_end_of_map. E820 entries leave on the
// out_ channel in table order; the final entry carries out_last_entry and the
// table size in out_entry_total. The first descriptor of a map also yields the
// two fixed low-memory entries, so one descriptor produces zero to three entries.
// The registers are read and written through the APB-style port and should only
// be written while no map is in flight.
// A descriptor is accepted every cycle as long as the entry queue has room. The
// first entry caused by a descriptor passes the classification register, the
// entry queue and the output register; the output side then delivers one entry
// per cycle while out_ready is high, taking a descriptor's entries in turn, and a
// four-deep queue of entry groups absorbs such bursts and receiver stalls; when it
// fills, in_ready drops until the receiver drains it. Reset clears the map state,
// empties the queue and returns the registers to their default values.
module memory_map_to_e820_converter_core import m2e_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BASE_W-1:0]     in_region_start,
  input  logic [PAGE_W-1:0]     in_page_count,
  input  logic [TYPE_W-1:0]     in_region_type,
  input  logic                  in_end_of_map,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BASE_W-1:0]     out_entry_base,
  output logic [LEN_W-1:0]      out_entry_length,
  output logic [2:0]            out_entry_kind,
  output logic                  out_last_entry,
  output logic [TOTAL_W-1:0]    out_entry_total,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t    cfg;
  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_wdata, q_head;
  result_t out_res;

  m2e_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  m2e_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_region_start (in_region_start),
    .in_page_count   (in_page_count),
    .in_region_type  (in_region_type),
    .in_end_of_map   (in_end_of_map),
    .cfg             (cfg),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  m2e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  m2e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_entry_base   = out_res.base;
  assign out_entry_length = out_res.length;
  assign out_entry_kind   = out_res.kind;
  assign out_last_entry   = out_res.last;
  assign out_entry_total  = out_res.total;

endmodule

@@ sv/m2e_regs.sv @@
// Configuration register file of the converter with its APB-style access port.
// Depends on m2e_pkg for register indexes, reset values and the cfg_t bundle.
module m2e_regs import m2e_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [20:0] low_top_r, low_top_nxt;
  logic [31:0] disk_base_r, disk_base_nxt;
  logic [30:0] disk_size_r, disk_size_nxt;
  logic [19:0] guard_base_r, guard_base_nxt;
  logic [32:0] disk_end_r, disk_end_nxt;
  logic [20:0] guard_end_r, guard_end_nxt;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    low_top_nxt    = low_top_r;
    disk_base_nxt  = disk_base_r;
    disk_size_nxt  = disk_size_r;
    guard_base_nxt = guard_base_r;
    if (wr) begin
      case (paddr[3:2])
        REG_LOW_TOP:    low_top_nxt    = pwdata[20:0];
        REG_DISK_BASE:  disk_base_nxt  = pwdata;
        REG_DISK_SIZE:  disk_size_nxt  = pwdata[30:0];
        REG_GUARD_BASE: guard_base_nxt = pwdata[19:0];
        default: ;
      endcase
    end
    disk_end_nxt  = {1'b0, disk_base_nxt} + {2'b0, disk_size_nxt};
    guard_end_nxt = {1'b0, guard_base_nxt} + SHIM_BYTES;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_top_r    <= LOW_TOP_RESET;
      disk_base_r  <= '0;
      disk_size_r  <= '0;
      guard_base_r <= '0;
      disk_end_r   <= '0;
      guard_end_r  <= SHIM_BYTES;
    end else begin
      low_top_r    <= low_top_nxt;
      disk_base_r  <= disk_base_nxt;
      disk_size_r  <= disk_size_nxt;
      guard_base_r <= guard_base_nxt;
      disk_end_r   <= disk_end_nxt;
      guard_end_r  <= guard_end_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LOW_TOP:    prdata = {11'b0, low_top_r};
      REG_DISK_BASE:  prdata = disk_base_r;
      REG_DISK_SIZE:  prdata = {1'b0, disk_size_r};
      REG_GUARD_BASE: prdata = {12'b0, guard_base_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.low_top    = low_top_r;
  assign cfg.disk_base  = disk_base_r;
  assign cfg.disk_end   = disk_end_r;
  assign cfg.guard_base = guard_base_r;
  assign cfg.guard_end  = guard_end_r;

endmodule

@@ sv/m2e_front.sv @@
// Front end: accepts descriptors, clips and classifies them, then merges them into
// the pending entry and packs the entries each request closes. Depends on m2e_pkg.
module m2e_front import m2e_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BASE_W-1:0] in_region_start,
  input  logic [PAGE_W-1:0] in_page_count,
  input  logic [TYPE_W-1:0] in_region_type,
  input  logic              in_end_of_map,
  input  cfg_t              cfg,
  input  logic              q_full,
  output logic              q_push,
  output bundle_t           q_data
);

  // Classification stage.
  logic              s1_valid_r, s1_valid_nxt;
  desc_t             s1_r, s1_nxt;
  logic              in_acc, s1_take;
  logic [BASE_W-1:0] pages_b;
  logic [LEN_W-1:0]  e_sum, e_m1;
  logic              is_low, disk_hit, guard_hit;

  assign s1_take  = s1_valid_r && !q_full;
  assign in_ready = !s1_valid_r || s1_take;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    pages_b  = {in_page_count, 12'b0};
    e_sum    = {1'b0, in_region_start} + {1'b0, pages_b};
    e_m1     = {1'b0, in_region_start} + {1'b0, pages_b} - ONE_MEG;
    is_low   = {1'b0, in_region_start} < ONE_MEG;
    s1_nxt.s   = is_low ? ONE_MEG[BASE_W-1:0] : in_region_start;
    s1_nxt.e   = e_sum;
    s1_nxt.len = is_low ? e_m1 : {1'b0, pages_b};
    s1_nxt.hit = e_sum > ONE_MEG;
    s1_nxt.eom = in_end_of_map;
    disk_hit = ({1'b0, s1_nxt.s} < {20'b0, cfg.disk_end}) && (e_sum > {21'b0, cfg.disk_base});
    guard_hit = ({1'b0, s1_nxt.s} < {32'b0, cfg.guard_end}) &&
                (e_sum > {33'b0, cfg.guard_base});
    s1_nxt.t = (disk_hit || guard_hit) ? KIND_RESERVED : kind_of(in_region_type);
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // Merge stage.
  logic               started_r, started_nxt;
  logic [TOTAL_W-1:0] tc_r, tc_nxt;
  logic [BASE_W-1:0]  pb_r, pb_nxt;
  logic [LEN_W-1:0]   pl_r, pl_nxt;
  kind_t              pk_r, pk_nxt;
  logic [LEN_W-1:0]   pe_r, pe_nxt;
  kind_t              pt_r, pt_nxt;
  logic [20:0]        lt;
  logic [BASE_W-1:0]  eff_base;
  logic [LEN_W-1:0]   eff_len;
  kind_t              eff_kind;
  logic [TOTAL_W-1:0] eff_tc;
  logic               doit, merge, newent;
  result_t            fixed_res, pend_res, final_res;
  bundle_t            bundle;
  logic [1:0]         n;

  always_comb begin
    lt = (cfg.low_top > ONE_MEG[20:0]) ? ONE_MEG[20:0] : cfg.low_top;
    if (!started_r) begin
      eff_base = {31'b0, lt};
      eff_len  = ONE_MEG - {32'b0, lt};
      eff_kind = KIND_RESERVED;
      eff_tc   = FIXED_ENTRIES;
    end else begin
      eff_base = pb_r;
      eff_len  = pl_r;
      eff_kind = pk_r;
      eff_tc   = tc_r;
    end
    doit   = s1_r.hit && (eff_tc < TOTAL_W'(MAX_ENTRIES));
    merge  = doit && (eff_tc > FIXED_ENTRIES) && ({1'b0, s1_r.s} == pe_r) && (s1_r.t == pt_r);
    newent = doit && !merge;

    pb_nxt = newent ? s1_r.s : eff_base;
    pk_nxt = newent ? s1_r.t : eff_kind;
    tc_nxt = newent ? eff_tc + 1'b1 : eff_tc;
    if (merge) begin
      pl_nxt = eff_len + s1_r.len;
    end else if (newent) begin
      pl_nxt = s1_r.len;
    end else begin
      pl_nxt = eff_len;
    end
    pe_nxt = doit ? s1_r.e : pe_r;
    pt_nxt = doit ? s1_r.t : pt_r;
    started_nxt = !s1_r.eom;

    fixed_res = '{base: '0, length: {32'b0, lt}, kind: KIND_USABLE, last: 1'b0, total: '0};
    pend_res  = '{base: eff_base, length: eff_len, kind: eff_kind, last: 1'b0, total: '0};
    final_res = '{base: pb_nxt, length: pl_nxt, kind: pk_nxt, last: 1'b1, total: tc_nxt};

    bundle = '0;
    n      = 2'd0;
    if (!started_r) begin
      bundle.res[n] = fixed_res;
      n = n + 2'd1;
    end
    if (newent) begin
      bundle.res[n] = pend_res;
      n = n + 2'd1;
    end
    if (s1_r.eom) begin
      bundle.res[n] = final_res;
      n = n + 2'd1;
    end
    bundle.cnt = n;
  end

  assign q_push = s1_take && (bundle.cnt != 2'd0);
  assign q_data = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      tc_r      <= '0;
    end else if (s1_take) begin
      started_r <= started_nxt;
      tc_r      <= s1_r.eom ? '0 : tc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      pb_r <= pb_nxt;
      pl_r <= pl_nxt;
      pk_r <= pk_nxt;
      pe_r <= pe_nxt;
      pt_r <= pt_nxt;
    end
  end

endmodule

@@ sv/m2e_queue.sv @@
// Short queue of packed entry groups between the front end and the output side.
// Depends on m2e_pkg for bundle_t and the queue depth.
module m2e_queue import m2e_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output bundle_t head
);

  bundle_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == QCNT_W'(QDEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/m2e_back.sv @@
// Output side: unpacks queued entry groups into the output register, one entry per
// cycle unless out_ready stalls it. Depends on m2e_pkg for bundle_t and result_t.
module m2e_back import m2e_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  bundle_t q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load, at_end;

  assign load   = !q_empty && (!out_valid_r || out_ready);
  assign at_end = idx_r == (q_head.cnt - 2'd1);
  assign q_pop  = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= q_head.res[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

@@ sv/m2e_checker.sv @@
// Port-level checks of the converter output channel, attached by a bind statement.
// Depends on m2e_pkg and on the port names of memory_map_to_e820_converter_core.
module m2e_checker import m2e_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BASE_W-1:0]  out_entry_base,
  input logic [LEN_W-1:0]   out_entry_length,
  input logic [2:0]         out_entry_kind,
  input logic               out_last_entry,
  input logic [TOTAL_W-1:0] out_entry_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_base) &&
      $stable(out_entry_length) && $stable(out_entry_kind) &&
      $stable(out_last_entry) && $stable(out_entry_total))
    else $error("output entry changed while stalled");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_entry |->
      out_entry_total >= FIXED_ENTRIES && out_entry_total <= TOTAL_W'(MAX_ENTRIES))
    else $error("table size out of range on the final entry");

  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_entry |-> out_entry_total == '0)
    else $error("table size reported on a non-final entry");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_kind == KIND_USABLE || out_entry_kind == KIND_RESERVED ||
      out_entry_kind == KIND_ACPI_RECLAIM || out_entry_kind == KIND_ACPI_NVS)
    else $error("entry kind is not a defined E820 kind");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind memory_map_to_e820_converter_core m2e_checker u_m2e_checker (.*);
